@@ rtl/core/lsac_pkg.sv @@
// Shared types, codes and constants for the line sensor array classifier.
// Holds the per-channel flag struct and the divide-by-six helper.
// Depends on nothing; imported by every module of the core.
package lsac_pkg;

  localparam int CHANNELS       = 6;
  localparam int SAMPLE_BITS    = 12;
  localparam int DARK_BITS      = 12;
  localparam int LIGHT_BITS     = 13;
  localparam int OFFSET_BITS    = 10;
  localparam int COUNT_BITS     = 3;
  localparam int MODE_BITS      = 3;
  localparam int CLASS_BITS     = 2;
  localparam int TARGET_BITS    = 3;
  localparam int VOTE_BITS      = 3;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [DARK_BITS-1:0]   dark_t;
  typedef logic [LIGHT_BITS-1:0]  light_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [MODE_BITS-1:0]   mode_t;
  typedef logic [CLASS_BITS-1:0]  class_t;
  typedef logic [TARGET_BITS-1:0] target_t;
  typedef logic [VOTE_BITS-1:0]   vote_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  // Frame modes
  localparam mode_t MODE_CLASSIFY     = 3'd0;
  localparam mode_t MODE_TRACK_PEAK   = 3'd1;
  localparam mode_t MODE_COMMIT_DARK  = 3'd2;
  localparam mode_t MODE_TRACK_TROUGH = 3'd3;
  localparam mode_t MODE_COMMIT_LIGHT = 3'd4;

  // Surface classes
  localparam class_t CLASS_BLACK = 2'd0;
  localparam class_t CLASS_WHITE = 2'd1;
  localparam class_t CLASS_LINE  = 2'd2;
  localparam class_t CLASS_GRAY  = 2'd3;

  // Target selections
  localparam target_t TARGET_BLACK      = 3'd0;
  localparam target_t TARGET_WHITE      = 3'd1;
  localparam target_t TARGET_LINE_WHITE = 3'd2;
  localparam target_t TARGET_GRAY       = 3'd3;
  localparam target_t TARGET_GRAY_BLACK = 3'd4;

  // Configuration register indexes
  localparam cfg_index_t CFG_TARGET_CLASS = 2'd0;
  localparam cfg_index_t CFG_VOTES_NEEDED = 2'd1;
  localparam cfg_index_t CFG_LIGHT_OFFSET = 2'd2;

  // Reset values
  localparam target_t TARGET_RESET = TARGET_LINE_WHITE;
  localparam vote_t   VOTES_RESET  = 3'd3;
  localparam offset_t OFFSET_RESET = 10'd500;
  localparam dark_t   DARK_RESET   = 12'd4000;
  localparam light_t  LIGHT_RESET  = 13'd700;
  localparam sample_t PEAK_RESET   = '0;
  localparam sample_t TROUGH_RESET = '1;

  // Classification limits
  localparam count_t BLACK_MIN_DARK  = 3'd5;
  localparam count_t WHITE_MIN_LIGHT = 3'd4;
  localparam count_t LINE_MIN_LIGHT  = 3'd2;

  // Division by six: (d * 5462) >> 15 is exact for every d below 4096
  localparam int DIV6_RECIP_BITS = 13;
  localparam int DIV6_SHIFT      = 15;
  localparam logic [DIV6_RECIP_BITS-1:0] DIV6_RECIP = 13'd5462;
  localparam int DIV6_PROD_BITS  = SAMPLE_BITS + DIV6_RECIP_BITS;

  typedef struct packed {
    logic dark;
    logic light;
  } lane_flags_t;

  function automatic sample_t div6(input sample_t d);
    logic [DIV6_PROD_BITS-1:0] prod;
    prod = DIV6_PROD_BITS'(d) * DIV6_PROD_BITS'(DIV6_RECIP);
    return sample_t'(prod >> DIV6_SHIFT);
  endfunction

endpackage

@@ rtl/core/lsac_lane.sv @@
// One channel lane: dark/light thresholds, peak and trough trackers.
// Flags the current sample against the thresholds held before this frame.
// Depends on lsac_pkg.
module lsac_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  lsac_pkg::mode_t       mode,
  input  lsac_pkg::sample_t     sample,
  input  lsac_pkg::offset_t     light_offset,
  output lsac_pkg::lane_flags_t flags
);
  import lsac_pkg::*;

  dark_t   dark_thr;
  light_t  light_thr;
  sample_t peak;
  sample_t trough;

  logic    above;
  sample_t gap;
  sample_t step;
  dark_t   dark_commit;
  sample_t trough_min;
  light_t  light_commit;

  always_comb begin
    flags.dark  = (sample >= dark_thr);
    flags.light = !flags.dark && (LIGHT_BITS'(sample) <= light_thr);
  end

  // Move the threshold from the peak towards the sample by a sixth of the gap
  always_comb begin
    above       = (peak >= sample);
    gap         = above ? (peak - sample) : (sample - peak);
    step        = div6(gap);
    dark_commit = DARK_BITS'(above ? (peak - step) : (peak + step));
    trough_min  = (sample < trough) ? sample : trough;
    light_commit = LIGHT_BITS'(trough_min) + LIGHT_BITS'(light_offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_thr  <= DARK_RESET;
      light_thr <= LIGHT_RESET;
      peak      <= PEAK_RESET;
      trough    <= TROUGH_RESET;
    end else if (accept) begin
      unique case (mode)
        MODE_TRACK_PEAK: begin
          if (sample > peak) peak <= sample;
        end
        MODE_COMMIT_DARK: begin
          dark_thr <= dark_commit;
          peak     <= PEAK_RESET;
        end
        MODE_TRACK_TROUGH: begin
          trough <= trough_min;
        end
        MODE_COMMIT_LIGHT: begin
          light_thr <= light_commit;
          trough    <= TROUGH_RESET;
        end
        default: begin
          // classify and undefined modes leave the lane state alone
        end
      endcase
    end
  end

endmodule

@@ rtl/core/lsac_merge.sv @@
// Merging stage: registers lane flags, counts them, classes the frame,
// runs the window vote and holds the result register and flow control.
// Depends on lsac_pkg.
module lsac_merge #(
  parameter int WINDOW_FRAMES = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  accept,
  input  lsac_pkg::mode_t       mode,
  input  lsac_pkg::lane_flags_t flags [lsac_pkg::CHANNELS],
  input  lsac_pkg::target_t     target_class,
  input  lsac_pkg::vote_t       votes_needed,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lsac_pkg::class_t      surface_class,
  output lsac_pkg::count_t      dark_channels,
  output lsac_pkg::count_t      light_channels,
  output logic                  window_end,
  output logic                  target_match
);
  import lsac_pkg::*;

  localparam int CW    = $clog2(WINDOW_FRAMES + 1);
  localparam int CMP_W = (CW > VOTE_BITS) ? CW : VOTE_BITS;

  logic                s1_valid;
  mode_t               s1_mode;
  logic [CHANNELS-1:0] s1_dark;
  logic [CHANNELS-1:0] s1_light;

  logic [CW-1:0] frame_in_window;
  logic [CW-1:0] agree_count;

  logic          s2_load;
  logic          s1_adv;
  count_t        dark_cnt;
  count_t        light_cnt;
  class_t        cls;
  logic          agrees;
  logic [CW-1:0] frame_next;
  logic [CW-1:0] agree_next;
  logic          at_end;
  logic          match;

  assign s2_load  = !out_valid || !out_stall;
  assign s1_adv   = !s1_valid || s2_load;
  assign in_stall = !s1_adv;
  assign accept   = in_valid && s1_adv;

  always_comb begin
    dark_cnt  = count_t'($countones(s1_dark));
    light_cnt = count_t'($countones(s1_light));

    priority if (dark_cnt >= BLACK_MIN_DARK)    cls = CLASS_BLACK;
    else if (light_cnt >= WHITE_MIN_LIGHT)      cls = CLASS_WHITE;
    else if (light_cnt >= LINE_MIN_LIGHT)       cls = CLASS_LINE;
    else                                        cls = CLASS_GRAY;

    unique case (target_class)
      TARGET_BLACK:      agrees = (cls == CLASS_BLACK);
      TARGET_WHITE:      agrees = (cls == CLASS_WHITE);
      TARGET_LINE_WHITE: agrees = (cls == CLASS_LINE) || (cls == CLASS_WHITE);
      TARGET_GRAY:       agrees = (cls == CLASS_GRAY);
      TARGET_GRAY_BLACK: agrees = (cls == CLASS_GRAY) || (cls == CLASS_BLACK);
      default:           agrees = 1'b0;
    endcase

    frame_next = frame_in_window + CW'(1);
    agree_next = agree_count + CW'(agrees);
    at_end     = (frame_next >= CW'(WINDOW_FRAMES));
    match      = (CMP_W'(agree_next) >= CMP_W'(votes_needed));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      frame_in_window <= '0;
      agree_count     <= '0;
    end else begin
      if (s1_adv) s1_valid <= in_valid;
      if (s2_load) out_valid <= s1_valid;
      if (s2_load && s1_valid && (s1_mode == MODE_CLASSIFY)) begin
        if (at_end) begin
          frame_in_window <= '0;
          agree_count     <= '0;
        end else begin
          frame_in_window <= frame_next;
          agree_count     <= agree_next;
        end
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= mode;
      for (int i = 0; i < CHANNELS; i++) begin
        s1_dark[i]  <= flags[i].dark;
        s1_light[i] <= flags[i].light;
      end
    end
    if (s2_load && s1_valid) begin
      surface_class  <= cls;
      dark_channels  <= dark_cnt;
      light_channels <= light_cnt;
      window_end     <= (s1_mode == MODE_CLASSIFY) && at_end;
      target_match   <= (s1_mode == MODE_CLASSIFY) && at_end && match;
    end
  end

endmodule

@@ rtl/core/line_sensor_array_classifier_core.sv @@
// Line sensor array classifier: six channel lanes and a merging stage.
// A frame's lane flags are registered in the merging stage, then its result.
// Throughput: one frame per cycle unless out_stall holds the pipeline;
// lane thresholds update at acceptance, so the very next frame uses them.
// Reset (rst, synchronous): thresholds, trackers, window counters and
// configuration return to their defaults; the pipeline empties.
module line_sensor_array_classifier_core #(
  parameter int WINDOW_FRAMES = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  lsac_pkg::cfg_index_t   cfg_index,
  input  lsac_pkg::offset_t      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lsac_pkg::mode_t        mode,
  input  lsac_pkg::sample_t      sample0,
  input  lsac_pkg::sample_t      sample1,
  input  lsac_pkg::sample_t      sample2,
  input  lsac_pkg::sample_t      sample3,
  input  lsac_pkg::sample_t      sample4,
  input  lsac_pkg::sample_t      sample5,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lsac_pkg::class_t       surface_class,
  output lsac_pkg::count_t       dark_channels,
  output lsac_pkg::count_t       light_channels,
  output logic                   window_end,
  output logic                   target_match
);
  import lsac_pkg::*;

  target_t target_class;
  vote_t   votes_needed;
  offset_t light_offset;

  sample_t     samples [CHANNELS];
  lane_flags_t flags   [CHANNELS];
  logic        accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_class <= TARGET_RESET;
      votes_needed <= VOTES_RESET;
      light_offset <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_CLASS: target_class <= target_t'(cfg_data);
        CFG_VOTES_NEEDED: votes_needed <= vote_t'(cfg_data);
        CFG_LIGHT_OFFSET: light_offset <= cfg_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign samples[0] = sample0;
  assign samples[1] = sample1;
  assign samples[2] = sample2;
  assign samples[3] = sample3;
  assign samples[4] = sample4;
  assign samples[5] = sample5;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    lsac_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .accept       (accept),
      .mode         (mode),
      .sample       (samples[g]),
      .light_offset (light_offset),
      .flags        (flags[g])
    );
  end

  lsac_merge #(
    .WINDOW_FRAMES (WINDOW_FRAMES)
  ) u_merge (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .accept         (accept),
    .mode           (mode),
    .flags          (flags),
    .target_class   (target_class),
    .votes_needed   (votes_needed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .surface_class  (surface_class),
    .dark_channels  (dark_channels),
    .light_channels (light_channels),
    .window_end     (window_end),
    .target_match   (target_match)
  );

endmodule

@@ rtl/core/lsac_checker.sv @@
// Port-level checks for the classifier core's result channel.
// Bound to line_sensor_array_classifier_core; depends on lsac_pkg.
module lsac_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input lsac_pkg::class_t  surface_class,
  input lsac_pkg::count_t  dark_channels,
  input lsac_pkg::count_t  light_channels,
  input logic              window_end,
  input logic              target_match
);
  import lsac_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(surface_class)
      && $stable(dark_channels) && $stable(light_channels)
      && $stable(window_end) && $stable(target_match))
    else $error("stalled result changed");

  a_match_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_match |-> window_end)
    else $error("match reported outside a window end");

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (({1'b0, dark_channels} + {1'b0, light_channels}) <= CHANNELS))
    else $error("dark and light counts exceed channel count");

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && (dark_channels >= BLACK_MIN_DARK) |-> surface_class == CLASS_BLACK)
    else $error("frame with enough dark channels not black");

  a_white: assert property (@(posedge clk) disable iff (rst)
    out_valid && (dark_channels < BLACK_MIN_DARK) && (light_channels >= WHITE_MIN_LIGHT)
      |-> surface_class == CLASS_WHITE)
    else $error("frame with enough light channels not white");

endmodule

bind line_sensor_array_classifier_core lsac_checker u_lsac_checker (.*);

@@ sim/line_sensor_array_classifier_core_tb.sv @@
// Testbench for line_sensor_array_classifier_core: directed and random frames,
// calibration runs and register changes, checked against an in-bench predictor.
// Depends on lsac_pkg and the core RTL only.
`timescale 1ns / 100ps

import lsac_pkg::*;

localparam int FRAMES_PER_WINDOW = 6;
// Index with no register behind it; writes there must change nothing
localparam cfg_index_t CFG_SPARE = 2'd3;

typedef sample_t [CHANNELS-1:0] frame_t;

typedef struct packed {
  class_t surface_class;
  count_t dark_channels;
  count_t light_channels;
  logic   window_end;
  logic   target_match;
} frame_result_t;

class surface_scoreboard;
  dark_t   dark_thr  [CHANNELS];
  light_t  light_thr [CHANNELS];
  sample_t peak      [CHANNELS];
  sample_t trough    [CHANNELS];
  int      agree_count;
  int      frame_in_window;
  target_t target;
  vote_t   votes_needed;
  offset_t light_offset;
  frame_result_t pending_results [$];
  int      errors;
  int      checked;
  int      windows;
  int      match_count;
  int      class_seen [4];

  function new();
    for (int i = 0; i < CHANNELS; i++) begin
      dark_thr[i]  = DARK_RESET;
      light_thr[i] = LIGHT_RESET;
      peak[i]      = PEAK_RESET;
      trough[i]    = TROUGH_RESET;
    end
    agree_count     = 0;
    frame_in_window = 0;
    target          = TARGET_RESET;
    votes_needed    = VOTES_RESET;
    light_offset    = OFFSET_RESET;
  endfunction

  function void apply_register(cfg_index_t idx, offset_t data);
    case (idx)
      CFG_TARGET_CLASS: target = target_t'(data);
      CFG_VOTES_NEEDED: votes_needed = vote_t'(data);
      CFG_LIGHT_OFFSET: light_offset = data;
      default: ;
    endcase
  endfunction

  function bit agrees(class_t cls);
    case (target)
      TARGET_BLACK:      return cls == CLASS_BLACK;
      TARGET_WHITE:      return cls == CLASS_WHITE;
      TARGET_LINE_WHITE: return cls == CLASS_LINE || cls == CLASS_WHITE;
      TARGET_GRAY:       return cls == CLASS_GRAY;
      TARGET_GRAY_BLACK: return cls == CLASS_GRAY || cls == CLASS_BLACK;
      default:           return 1'b0;
    endcase
  endfunction

  // Class the frame with the thresholds as they stand, then update state
  function void note_frame(mode_t m, frame_t f);
    frame_result_t r;
    class_t cls;
    int dark_n;
    int light_n;
    int p;
    int s;
    int t;
    dark_n  = 0;
    light_n = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (f[i] >= dark_thr[i]) dark_n++;
      else if (f[i] <= light_thr[i]) light_n++;
    end
    if (dark_n >= BLACK_MIN_DARK) cls = CLASS_BLACK;
    else if (light_n >= WHITE_MIN_LIGHT) cls = CLASS_WHITE;
    else if (light_n >= LINE_MIN_LIGHT) cls = CLASS_LINE;
    else cls = CLASS_GRAY;
    r.surface_class  = cls;
    r.dark_channels  = count_t'(dark_n);
    r.light_channels = count_t'(light_n);
    r.window_end     = 1'b0;
    r.target_match   = 1'b0;
    case (m)
      MODE_CLASSIFY: begin
        if (agrees(cls)) agree_count++;
        frame_in_window++;
        if (frame_in_window >= FRAMES_PER_WINDOW) begin
          r.window_end    = 1'b1;
          r.target_match  = agree_count >= votes_needed;
          frame_in_window = 0;
          agree_count     = 0;
          windows++;
          if (r.target_match) match_count++;
        end
      end
      MODE_TRACK_PEAK: begin
        for (int i = 0; i < CHANNELS; i++)
          if (f[i] > peak[i]) peak[i] = f[i];
      end
      MODE_COMMIT_DARK: begin
        // Difference may go either way; division truncates towards zero
        for (int i = 0; i < CHANNELS; i++) begin
          p = peak[i];
          s = f[i];
          if (p >= s) t = p - (p - s) / 6;
          else t = p + (s - p) / 6;
          dark_thr[i] = dark_t'(t);
          peak[i]     = PEAK_RESET;
        end
      end
      MODE_TRACK_TROUGH: begin
        for (int i = 0; i < CHANNELS; i++)
          if (f[i] < trough[i]) trough[i] = f[i];
      end
      MODE_COMMIT_LIGHT: begin
        for (int i = 0; i < CHANNELS; i++) begin
          t = trough[i];
          if (f[i] < t) t = f[i];
          light_thr[i] = light_t'(t + light_offset);
          trough[i]    = TROUGH_RESET;
        end
      end
      default: ;
    endcase
    class_seen[cls]++;
    pending_results.push_back(r);
  endfunction

  function void compare(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(frame_result_t got);
    frame_result_t want;
    if (pending_results.size() == 0) begin
      $error("result transaction with no frame outstanding");
      errors++;
      return;
    end
    want = pending_results.pop_front();
    checked++;
    compare("surface_class", 8'(want.surface_class), 8'(got.surface_class));
    compare("dark_channels", 8'(want.dark_channels), 8'(got.dark_channels));
    compare("light_channels", 8'(want.light_channels), 8'(got.light_channels));
    compare("window_end", 8'(want.window_end), 8'(got.window_end));
    compare("target_match", 8'(want.target_match), 8'(got.target_match));
  endfunction
endclass

module line_sensor_array_classifier_core_tb;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_TARGET_CLASS;
  offset_t    cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  mode_t      mode      = MODE_CLASSIFY;
  sample_t    sample0   = '0;
  sample_t    sample1   = '0;
  sample_t    sample2   = '0;
  sample_t    sample3   = '0;
  sample_t    sample4   = '0;
  sample_t    sample5   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  class_t     surface_class;
  count_t     dark_channels;
  count_t     light_channels;
  logic       window_end;
  logic       target_match;

  surface_scoreboard sb = new();

  int frames_sent = 0;
  int burst_left  = 0;
  int stall_style = 0;
  int style_left  = 0;
  int run_left    = 0;
  logic stall_run = 1'b0;

  line_sensor_array_classifier_core #(
    .WINDOW_FRAMES(FRAMES_PER_WINDOW)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .sample0       (sample0),
    .sample1       (sample1),
    .sample2       (sample2),
    .sample3       (sample3),
    .sample4       (sample4),
    .sample5       (sample5),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .surface_class (surface_class),
    .dark_channels (dark_channels),
    .light_channels(light_channels),
    .window_end    (window_end),
    .target_match  (target_match)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Note inputs before checking results, so a short pipeline still lines up
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.apply_register(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.note_frame(mode, {sample5, sample4, sample3, sample2, sample1, sample0});
      if (out_valid && !out_stall)
        sb.check_result({surface_class, dark_channels, light_channels, window_end,
                         target_match});
    end
  end

  // Receiver back-pressure: switch between free flow, light, heavy and long runs
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 200);
    end
    style_left--;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 10);
          stall_run = !stall_run;
        end
        run_left--;
        out_stall <= stall_run;
      end
    endcase
  end

  task automatic send_frame(input mode_t m, input frame_t f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    mode     <= m;
    sample0  <= f[0];
    sample1  <= f[1];
    sample2  <= f[2];
    sample3  <= f[3];
    sample4  <= f[4];
    sample5  <= f[5];
    frames_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_register(input cfg_index_t idx, input offset_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, drain every outstanding result, then cover the pipeline depth
  task automatic settle();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending_results.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic frame_t uniform(input sample_t v);
    return {CHANNELS{v}};
  endfunction

  function automatic frame_t random_frame(input int lo, input int hi);
    frame_t f;
    for (int i = 0; i < CHANNELS; i++) f[i] = sample_t'($urandom_range(lo, hi));
    return f;
  endfunction

  // Aim each lane at the dark, light or middle band of its current thresholds
  function automatic frame_t shaped_frame();
    frame_t f;
    int n_dark;
    int n_light;
    int start;
    int lane;
    int lo;
    int hi;
    n_dark  = $urandom_range(0, CHANNELS);
    n_light = $urandom_range(0, CHANNELS - n_dark);
    start   = $urandom_range(0, CHANNELS - 1);
    for (int k = 0; k < CHANNELS; k++) begin
      lane = (start + k) % CHANNELS;
      if (k < n_dark) begin
        lo = int'(sb.dark_thr[lane]);
        f[lane] = ($urandom_range(0, 3) == 0) ? sample_t'(lo)
                                              : sample_t'($urandom_range(lo, 4095));
      end else if (k < n_dark + n_light) begin
        hi = (sb.light_thr[lane] > 4095) ? 4095 : int'(sb.light_thr[lane]);
        f[lane] = ($urandom_range(0, 3) == 0) ? sample_t'(hi)
                                              : sample_t'($urandom_range(0, hi));
      end else begin
        lo = int'(sb.light_thr[lane]) + 1;
        hi = int'(sb.dark_thr[lane]) - 1;
        if (lo <= hi)
          f[lane] = ($urandom_range(0, 3) == 0) ? sample_t'(hi)
                                                : sample_t'($urandom_range(lo, hi));
        else
          f[lane] = sample_t'($urandom_range(0, 4095));
      end
    end
    return f;
  endfunction

  initial begin
    int vote_pattern [8];
    int phase_end;
    int n;
    target_t tgt;
    vote_t votes;
    offset_t junk;
    offset_t offset_val;
    vote_pattern = '{0, 6, 7, 1, 3, 2, 5, 4};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_register(CFG_TARGET_CLASS, offset_t'(TARGET_RESET));
    set_register(CFG_VOTES_NEEDED, offset_t'(VOTES_RESET));
    set_register(CFG_LIGHT_OFFSET, OFFSET_RESET);
    set_register(CFG_SPARE, '1);

    // Threshold boundaries with reset calibration; two full windows
    send_frame(MODE_CLASSIFY, uniform('0));
    send_frame(MODE_CLASSIFY, uniform('1));
    send_frame(MODE_CLASSIFY, uniform(sample_t'(DARK_RESET - 1)));
    send_frame(MODE_CLASSIFY, uniform(DARK_RESET));
    send_frame(MODE_CLASSIFY, uniform(sample_t'(LIGHT_RESET)));
    send_frame(MODE_CLASSIFY, uniform(sample_t'(LIGHT_RESET + 1)));
    send_frame(MODE_CLASSIFY, {12'd0, {5{DARK_RESET}}});
    send_frame(MODE_CLASSIFY, {{2{12'd0}}, {4{DARK_RESET}}});
    send_frame(MODE_CLASSIFY, {{2{12'd2000}}, {4{12'd0}}});
    send_frame(MODE_CLASSIFY, {{3{12'd2000}}, {3{12'd0}}});
    send_frame(MODE_CLASSIFY, {{5{12'd2000}}, 12'd0});
    send_frame(MODE_CLASSIFY, {12'hFFF, 12'd0, 12'hAAA, 12'h555, 12'd700, 12'd701});
    // Undefined modes leave all state alone
    send_frame(mode_t'(MODE_COMMIT_LIGHT + 1), random_frame(0, 4095));
    send_frame('1, uniform('1));
    // Dark commit below the peak, then above a cleared peak
    send_frame(MODE_TRACK_PEAK, random_frame(2000, 4095));
    send_frame(MODE_TRACK_PEAK, uniform('1));
    send_frame(MODE_COMMIT_DARK, uniform('0));
    send_frame(MODE_COMMIT_DARK, {12'd2048, 12'd7, 12'd6, 12'd1, 12'd0, 12'hFFF});
    // Light commit from tracked troughs, then from untouched troughs
    send_frame(MODE_TRACK_TROUGH, random_frame(0, 600));
    send_frame(MODE_TRACK_TROUGH, uniform('1));
    send_frame(MODE_COMMIT_LIGHT, uniform('1));
    send_frame(MODE_COMMIT_LIGHT, uniform('1));
    send_frame(MODE_CLASSIFY, uniform('0));
    send_frame(MODE_CLASSIFY, random_frame(0, 4095));

    for (int phase = 0; phase < 16; phase++) begin
      settle();
      if (phase < 8) begin
        tgt   = target_t'(phase);
        votes = vote_t'(vote_pattern[phase]);
        offset_val = (phase == 0) ? offset_t'(0) :
                     (phase == 1) ? offset_t'('1) : offset_t'($urandom_range(0, 1023));
      end else begin
        tgt = ($urandom_range(0, 4) == 0)
              ? target_t'($urandom_range(TARGET_GRAY_BLACK + 1, 7))
              : target_t'($urandom_range(TARGET_BLACK, TARGET_GRAY_BLACK));
        votes      = vote_t'($urandom_range(0, 7));
        offset_val = offset_t'($urandom_range(0, 1023));
      end
      // Upper data bits beyond the register width must be ignored
      junk = offset_t'($urandom);
      set_register(CFG_TARGET_CLASS, {junk[OFFSET_BITS-1:TARGET_BITS], tgt});
      junk = offset_t'($urandom);
      set_register(CFG_VOTES_NEEDED, {junk[OFFSET_BITS-1:VOTE_BITS], votes});
      set_register(CFG_LIGHT_OFFSET, offset_val);

      phase_end = frames_sent + 100;
      while (frames_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            n = $urandom_range(1, 6);
            repeat (n)
              send_frame(MODE_TRACK_PEAK, ($urandom_range(0, 3) == 0)
                         ? random_frame(0, 4095) : random_frame(2500, 4095));
            // Leave a calibration unfinished now and then
            if ($urandom_range(0, 7) != 0)
              send_frame(MODE_COMMIT_DARK, ($urandom_range(0, 3) == 0)
                         ? random_frame(0, 4095) : random_frame(0, 1500));
          end
          2, 3: begin
            n = $urandom_range(1, 6);
            repeat (n)
              send_frame(MODE_TRACK_TROUGH, ($urandom_range(0, 3) == 0)
                         ? random_frame(0, 4095) : random_frame(0, 1200));
            if ($urandom_range(0, 7) != 0)
              send_frame(MODE_COMMIT_LIGHT, ($urandom_range(0, 3) == 0)
                         ? random_frame(0, 4095) : random_frame(0, 1500));
          end
          4, 5, 6, 7, 8: begin
            n = $urandom_range(1, 3) * FRAMES_PER_WINDOW + $urandom_range(0, 2);
            repeat (n) send_frame(MODE_CLASSIFY, shaped_frame());
          end
          default: begin
            n = $urandom_range(1, 3);
            repeat (n) send_frame(mode_t'($urandom_range(0, 7)), random_frame(0, 4095));
          end
        endcase
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $error("%0d results never arrived", sb.pending_results.size());
      sb.errors++;
    end
    $display("Sent %0d frames, checked %0d results; %0d windows closed, %0d matched.",
             frames_sent, sb.checked, sb.windows, sb.match_count);
    $display("Frames classed black %0d, white %0d, line %0d, gray %0d.",
             sb.class_seen[CLASS_BLACK], sb.class_seen[CLASS_WHITE],
             sb.class_seen[CLASS_LINE], sb.class_seen[CLASS_GRAY]);
    if (sb.errors == 0)
      $display("line_sensor_array_classifier_core verification clean");
    else
      $display("line_sensor_array_classifier_core verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("line_sensor_array_classifier_core verification failed");
    $finish;
  end

endmodule
